@@ rtl/core/a1crp_pkg.sv @@
// Package for the A1 cell reference parser.
// Holds the parse phase type, character codes, radices and default widths.
// No dependencies.
package a1crp_pkg;

	localparam int COL_BITS_DEF = 24;
	localparam int ROW_BITS_DEF = 24;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_Z   = 8'h5A;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_LO_Z   = 8'h7A;

	localparam int COL_RADIX = 26;
	localparam int ROW_RADIX = 10;

	typedef enum logic [2:0] {
		PH_START,
		PH_COLDOL,
		PH_LETTERS,
		PH_ROWDOL,
		PH_DIGITS,
		PH_DONE,
		PH_FAIL
	} phase_t;

endpackage

@@ rtl/core/a1_cell_reference_parser.sv @@
// A1 cell reference parser: top level, one character per transaction.
// Depends on a1crp_pkg.
//
// Usage: the item channel (item_valid, item_stall, ch, last) carries one
// ASCII character per transaction, with last high on the final character of
// a reference. The result channel (result_valid, result_stall, ref_valid,
// col_index, row_index, ref_kind) carries one transaction per reference,
// produced by the character that carries last; other characters give none.
// A character is captured in an input register, parsed by one step of logic
// against the parse state, and a finished reference lands in the result
// register. The result register is loaded as its last character leaves the
// input register; one character is taken in every cycle without item_stall.
// When the receiver stalls, the result register holds; characters without
// last still go through, and a character with last waits in the input
// register, which then stalls the item channel.
// Reset clears the parse state to the start of a reference and empties
// both registers.
module a1_cell_reference_parser #(
	parameter int COL_BITS = a1crp_pkg::COL_BITS_DEF,
	parameter int ROW_BITS = a1crp_pkg::ROW_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  logic [7:0]          ch,
	input  logic                last,
	output logic                result_valid,
	input  logic                result_stall,
	output logic                ref_valid,
	output logic [COL_BITS-1:0] col_index,
	output logic [ROW_BITS-1:0] row_index,
	output logic [1:0]          ref_kind
);
	import a1crp_pkg::*;

	localparam int CW = COL_BITS + 6;
	localparam int RW = ROW_BITS + 5;

	logic               valid_s1;
	logic [7:0]         ch_s1;
	logic               last_s1;

	phase_t             phase_q, phase_n;
	logic [COL_BITS:0]  col_acc_q, col_acc_n;
	logic [ROW_BITS:0]  row_acc_q, row_acc_n;
	logic               col_mark_q, col_mark_n;
	logic               row_mark_q, row_mark_n;
	logic               ovf_q, ovf_n;

	logic               result_valid_q;
	logic               ref_valid_q;
	logic [COL_BITS-1:0] col_index_q;
	logic [ROW_BITS-1:0] row_index_q;
	logic [1:0]         ref_kind_q;

	logic               is_letter, is_digit, is_dollar;
	logic               do_letter, do_digit;
	logic [CW-1:0]      col_mul;
	logic [RW-1:0]      row_mul;
	logic               col_over, row_over;
	logic               advance, fire, ok;
	logic [COL_BITS:0]  col_dec;
	logic [ROW_BITS:0]  row_dec;

	assign advance    = !last_s1 || !result_valid_q || !result_stall;
	assign fire       = valid_s1 && advance;
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			ch_s1   <= ch;
			last_s1 <= last;
		end
	end

	assign is_letter = ((ch_s1 >= CH_UP_A) && (ch_s1 <= CH_UP_Z)) ||
	                   ((ch_s1 >= CH_LO_A) && (ch_s1 <= CH_LO_Z));
	assign is_digit  = (ch_s1 >= CH_ZERO) && (ch_s1 <= CH_NINE);
	assign is_dollar = (ch_s1 == CH_DOLLAR);

	// For letters of either case the low five bits give A=1 through Z=26.
	assign col_mul  = CW'(col_acc_q) * CW'(COL_RADIX) + CW'(ch_s1[4:0]);
	assign row_mul  = RW'(row_acc_q) * RW'(ROW_RADIX) + RW'(ch_s1[3:0]);
	assign col_over = col_mul > (CW'(1) << COL_BITS);
	assign row_over = row_mul > (RW'(1) << ROW_BITS);

	always_comb begin
		phase_n    = phase_q;
		col_mark_n = col_mark_q;
		row_mark_n = row_mark_q;
		do_letter  = 1'b0;
		do_digit   = 1'b0;
		unique case (phase_q)
			PH_START: begin
				if (is_dollar) begin
					col_mark_n = 1'b1;
					phase_n    = PH_COLDOL;
				end else if (is_letter) begin
					do_letter = 1'b1;
					phase_n   = PH_LETTERS;
				end else begin
					phase_n = PH_FAIL;
				end
			end
			PH_COLDOL: begin
				if (is_letter) begin
					do_letter = 1'b1;
					phase_n   = PH_LETTERS;
				end else begin
					phase_n = PH_FAIL;
				end
			end
			PH_LETTERS: begin
				if (is_letter) begin
					do_letter = 1'b1;
				end else if (is_dollar) begin
					row_mark_n = 1'b1;
					phase_n    = PH_ROWDOL;
				end else if (is_digit) begin
					do_digit = 1'b1;
					phase_n  = PH_DIGITS;
				end else begin
					phase_n = PH_FAIL;
				end
			end
			PH_ROWDOL: begin
				if (is_digit) begin
					do_digit = 1'b1;
					phase_n  = PH_DIGITS;
				end else begin
					phase_n = PH_FAIL;
				end
			end
			PH_DIGITS: begin
				if (is_digit) begin
					do_digit = 1'b1;
				end else begin
					phase_n = PH_DONE;
				end
			end
			default: begin
				phase_n = phase_q;
			end
		endcase

		col_acc_n = col_acc_q;
		row_acc_n = row_acc_q;
		ovf_n     = ovf_q;
		if (!ovf_q && do_letter) begin
			if (col_over) begin
				ovf_n = 1'b1;
			end else begin
				col_acc_n = col_mul[COL_BITS:0];
			end
		end
		if (!ovf_q && do_digit) begin
			if (row_over) begin
				ovf_n = 1'b1;
			end else begin
				row_acc_n = row_mul[ROW_BITS:0];
			end
		end

		ok = ((phase_n == PH_DIGITS) || (phase_n == PH_DONE)) && !ovf_n &&
		     (row_acc_n != '0) && (col_acc_n != '0);
		col_dec = col_acc_n - (COL_BITS+1)'(1);
		row_dec = row_acc_n - (ROW_BITS+1)'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_START;
			col_acc_q  <= '0;
			row_acc_q  <= '0;
			col_mark_q <= 1'b0;
			row_mark_q <= 1'b0;
			ovf_q      <= 1'b0;
		end else if (fire) begin
			if (last_s1) begin
				phase_q    <= PH_START;
				col_acc_q  <= '0;
				row_acc_q  <= '0;
				col_mark_q <= 1'b0;
				row_mark_q <= 1'b0;
				ovf_q      <= 1'b0;
			end else begin
				phase_q    <= phase_n;
				col_acc_q  <= col_acc_n;
				row_acc_q  <= row_acc_n;
				col_mark_q <= col_mark_n;
				row_mark_q <= row_mark_n;
				ovf_q      <= ovf_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fire && last_s1) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && last_s1) begin
			ref_valid_q <= ok;
			col_index_q <= ok ? col_dec[COL_BITS-1:0] : '0;
			row_index_q <= ok ? row_dec[ROW_BITS-1:0] : '0;
			ref_kind_q  <= ok ? {row_mark_n, col_mark_n} : 2'b00;
		end
	end

	assign result_valid = result_valid_q;
	assign ref_valid    = ref_valid_q;
	assign col_index    = col_index_q;
	assign row_index    = row_index_q;
	assign ref_kind     = ref_kind_q;

endmodule
